// ===== design/fmpd_pkg.sv =====
// Shared constants, types and the arctangent table of the FM phase discriminator.
package fmpd_pkg;

	localparam int IN_W   = 16;
	localparam int OUT_W  = 20;
	localparam int GAIN_W = 20;
	localparam int Z_W    = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int ATAN_LEN = 24;

	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(64000);

	// register index, taken from paddr[2]
	localparam logic REG_GAIN = 1'b0;

	localparam logic [Z_W-1:0] Z_ZERO    = 32'h0000_0000;
	localparam logic [Z_W-1:0] Z_QUARTER = 32'h4000_0000;
	localparam logic [Z_W-1:0] Z_HALF    = 32'h8000_0000;
	localparam logic [Z_W-1:0] Z_THREEQ  = 32'hC000_0000;

	typedef struct packed {
		logic vld;
		logic byp;   // exact phase already set, cells pass it through
	} ctl_t;

	// atan(2^-k), 2^32 per turn, rounded
	function automatic logic [Z_W-1:0] atan_entry(input int unsigned k);
		logic [Z_W-1:0] v;
		unique case (k)
			0:  v = 32'h2000_0000;
			1:  v = 32'h12E4_051E;
			2:  v = 32'h09FB_385B;
			3:  v = 32'h0511_11D4;
			4:  v = 32'h028B_0D43;
			5:  v = 32'h0145_D7E1;
			6:  v = 32'h00A2_F61E;
			7:  v = 32'h0051_7C55;
			8:  v = 32'h0028_BE53;
			9:  v = 32'h0014_5F2F;
			10: v = 32'h000A_2F98;
			11: v = 32'h0005_17CC;
			12: v = 32'h0002_8BE6;
			13: v = 32'h0001_45F3;
			14: v = 32'h0000_A2FA;
			15: v = 32'h0000_517D;
			16: v = 32'h0000_28BE;
			17: v = 32'h0000_145F;
			18: v = 32'h0000_0A30;
			19: v = 32'h0000_0518;
			20: v = 32'h0000_028C;
			21: v = 32'h0000_0146;
			22: v = 32'h0000_00A3;
			23: v = 32'h0000_0051;
			default: v = Z_ZERO;
		endcase
		return v;
	endfunction

endpackage

// ===== design/fmpd_if.sv =====
// Valid/ready channel interfaces for sample pairs in and frequency words out.
interface fmpd_in_if import fmpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [IN_W-1:0]  i_sample;
	logic signed [IN_W-1:0]  q_sample;

	modport source (output valid, i_sample, q_sample, input ready);
	modport sink   (input valid, i_sample, q_sample, output ready);
endinterface

interface fmpd_out_if import fmpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] freq_out;

	modport source (output valid, freq_out, input ready);
	modport sink   (input valid, freq_out, output ready);
endinterface

// ===== design/fmpd_cell.sv =====
// One CORDIC vectoring cell: a fixed shift and a fixed arctangent step, or a pass-through when bypassed.
module fmpd_cell import fmpd_pkg::*; #(
	parameter int K  = 0,
	parameter int XW = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  ctl_t                 ctl_in,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic [Z_W-1:0]       z_in,
	output ctl_t                 ctl_out,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic [Z_W-1:0]       z_out
);

	localparam logic [Z_W-1:0] ATAN_K = atan_entry(K);

	ctl_t                 ctl_q;
	logic signed [XW-1:0] x_q, y_q, x_nx, y_nx, xs, ys;
	logic [Z_W-1:0]       z_q, z_nx;

	always_comb begin
		xs = x_in >>> K;
		ys = y_in >>> K;
		if (ctl_in.byp) begin
			x_nx = x_in;
			y_nx = y_in;
			z_nx = z_in;
		end else if (!y_in[XW-1]) begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + ATAN_K;
		end else begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - ATAN_K;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_in.vld) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
	end

	assign ctl_out = ctl_q;
	assign x_out   = x_q;
	assign y_out   = y_q;
	assign z_out   = z_q;

endmodule

// ===== design/fmpd_scale.sv =====
// Phase rounding, difference against the previous phase, gain multiply and output register.
module fmpd_scale import fmpd_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  ctl_t                    ctl_in,
	input  logic [Z_W-1:0]          z_in,
	input  logic [GAIN_W-1:0]       gain,
	output logic                    out_vld,
	output logic signed [OUT_W-1:0] freq
);

	localparam int PW = GAIN_W + ANGLE_WIDTH + 1;
	localparam logic [Z_W-1:0] HALF_LSB = Z_W'(1) << (Z_W - 1 - ANGLE_WIDTH);

	logic [Z_W-1:0]                zr;
	logic [ANGLE_WIDTH-1:0]        phase, last_q;
	logic signed [ANGLE_WIDTH-1:0] delta_q;
	logic                          dvld_q, out_vld_q;
	logic signed [PW-1:0]          prod;
	logic signed [OUT_W-1:0]       freq_q;

	always_comb begin
		zr    = z_in + HALF_LSB;
		phase = zr[Z_W-1 -: ANGLE_WIDTH];
		prod  = PW'($signed({1'b0, gain})) * PW'(delta_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_q    <= 1'b0;
			out_vld_q <= 1'b0;
			last_q    <= '0;
		end else if (adv) begin
			dvld_q    <= ctl_in.vld;
			out_vld_q <= dvld_q;
			if (ctl_in.vld)
				last_q <= phase;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_in.vld)
			delta_q <= phase - last_q;   // wraps to +/- half a turn
		if (adv && dvld_q)
			freq_q <= prod[ANGLE_WIDTH +: OUT_W];
	end

	assign out_vld = out_vld_q;
	assign freq    = freq_q;

endmodule

// ===== design/fm_phase_discriminator.sv =====
// FM phase discriminator top level: quadrant fold, row of CORDIC cells, differencing and scaling.
// Register path: input register, cell row, difference register, output register to out_ch.
// Throughput: one word per cycle while out_ch takes words; the cell row and the two
//   scaling stages all hold together when the output register is full and not taken.
// Reset clears every valid bit and the stored phase, and sets demod_gain to 64000.
module fm_phase_discriminator import fmpd_pkg::*; #(
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fmpd_in_if.sink           in_ch,
	fmpd_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int XW = SAMPLE_WIDTH + 2;
	localparam int NC = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	logic                        adv, out_vld;
	logic [GAIN_W-1:0]           gain_q;
	logic signed [SAMPLE_WIDTH-1:0] i_sw, q_sw;
	logic signed [XW-1:0]        ix, qy, x_pre, y_pre;
	logic [Z_W-1:0]              z_pre;
	logic                        byp_pre;

	ctl_t                 ctl_c [0:NC];
	logic signed [XW-1:0] x_c   [0:NC];
	logic signed [XW-1:0] y_c   [0:NC];
	logic [Z_W-1:0]       z_c   [0:NC];

	ctl_t                 ctl_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic [Z_W-1:0]       z_s1;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GAIN) ? DATA_W'(gain_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_GAIN) begin
			gain_q <= pwdata[GAIN_W-1:0];
		end
	end

	assign adv         = !out_vld || out_ch.ready;
	assign in_ch.ready = adv;

	// quadrant fold into the right half plane; Q of zero gets its exact phase
	always_comb begin
		i_sw    = SAMPLE_WIDTH'(in_ch.i_sample);
		q_sw    = SAMPLE_WIDTH'(in_ch.q_sample);
		ix      = XW'(i_sw);
		qy      = XW'(q_sw);
		x_pre   = ix;
		y_pre   = qy;
		z_pre   = Z_ZERO;
		byp_pre = 1'b0;
		if (qy == '0) begin
			byp_pre = 1'b1;
			if (ix > 0)
				z_pre = Z_ZERO;
			else if (ix < 0)
				z_pre = Z_HALF;
			else
				z_pre = Z_QUARTER;
		end else if (ix[XW-1]) begin
			if (!qy[XW-1]) begin
				x_pre = qy;
				y_pre = -ix;
				z_pre = Z_QUARTER;
			end else begin
				x_pre = -qy;
				y_pre = ix;
				z_pre = Z_THREEQ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld <= in_ch.valid;
			ctl_s1.byp <= byp_pre;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_ch.valid) begin
			x_s1 <= x_pre;
			y_s1 <= y_pre;
			z_s1 <= z_pre;
		end
	end

	assign ctl_c[0] = ctl_s1;
	assign x_c[0]   = x_s1;
	assign y_c[0]   = y_s1;
	assign z_c[0]   = z_s1;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		fmpd_cell #(
			.K  (k),
			.XW (XW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_in  (ctl_c[k]),
			.x_in    (x_c[k]),
			.y_in    (y_c[k]),
			.z_in    (z_c[k]),
			.ctl_out (ctl_c[k+1]),
			.x_out   (x_c[k+1]),
			.y_out   (y_c[k+1]),
			.z_out   (z_c[k+1])
		);
	end

	fmpd_scale #(
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_c[NC]),
		.z_in    (z_c[NC]),
		.gain    (gain_q),
		.out_vld (out_vld),
		.freq    (out_ch.freq_out)
	);

	assign out_ch.valid = out_vld;

endmodule

// ===== design/fmpd_checker.sv =====
// Port-level checks for the FM phase discriminator, bound to the top level.
module fmpd_checker import fmpd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] freq_out,
	input logic                    psel,
	input logic                    penable,
	input logic                    pwrite,
	input logic [ADDR_W-1:0]       paddr,
	input logic [DATA_W-1:0]       pwdata,
	input logic [DATA_W-1:0]       prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(freq_out))
		else $error("output word changed while stalled");

	// input side is held exactly when the output register is full and not taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output register state");

	a_gain_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == REG_GAIN ##1 paddr[2] == REG_GAIN
		|-> prdata[GAIN_W-1:0] == $past(pwdata[GAIN_W-1:0]))
		else $error("gain register readback mismatch");

	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[DATA_W-1:GAIN_W] == '0)
		else $error("unused prdata bits not zero");

endmodule

bind fm_phase_discriminator fmpd_checker u_fmpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.freq_out  (out_ch.freq_out),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

// ===== tb/sv/tb_fm_phase_discriminator.sv =====
// Self-checking testbench for the FM phase discriminator: CORDIC phase, differencing, gain.
module tb_fm_phase_discriminator;
	import fmpd_pkg::*;

	localparam int PIPE_LAT = CORDIC_STAGES_DEF + 3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam real TWO_PI = 6.283185307179586;

	localparam logic [ADDR_W-1:0] ADDR_GAIN  = {REG_GAIN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_SPARE = 3'b100;

	localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

	// atan(2^-k) in 2^32 per turn
	localparam logic [Z_W-1:0] ATAN_TBL [16] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	fmpd_in_if  in_ch ();
	fmpd_out_if out_ch ();

	fm_phase_discriminator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [GAIN_W-1:0]       gain_model;
	logic [15:0]             last_phase_model;
	logic signed [OUT_W-1:0] freq_expected_q [$];
	logic signed [OUT_W-1:0] freq_want;
	int                      errors;
	int                      quiet_cycles;
	bit                      idle_on;
	bit                      stall_on;
	int                      hold_len;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// phase of (i, q) in 2^32 per turn; Q of zero gives the exact axis angle
	function automatic logic [Z_W-1:0] cordic_angle(input logic signed [IN_W-1:0] i_s,
			input logic signed [IN_W-1:0] q_s);
		longint x, y, xs, ys, t;
		logic [Z_W-1:0] z;
		x = i_s;
		y = q_s;
		z = Z_ZERO;
		if (y == 0) begin
			if (x > 0) return Z_ZERO;
			if (x < 0) return Z_HALF;
			return Z_QUARTER;
		end
		// fold the left half plane into the right one
		if (x < 0) begin
			t = x;
			if (y > 0) begin
				x = y;
				y = -t;
				z = Z_QUARTER;
			end else begin
				x = -y;
				y = t;
				z = Z_THREEQ;
			end
		end
		for (int k = 0; k < CORDIC_STAGES_DEF; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TBL[k];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TBL[k];
			end
		end
		return z;
	endfunction

	function automatic logic signed [OUT_W-1:0] predict_freq(input logic signed [IN_W-1:0] i_s,
			input logic signed [IN_W-1:0] q_s);
		logic [Z_W-1:0] z;
		logic [15:0] phase;
		logic signed [15:0] delta;
		longint g, d, prod;
		z = cordic_angle(i_s, q_s) + 32'h0000_8000;
		phase = z[31:16];
		delta = phase - last_phase_model;
		g = gain_model;
		d = delta;
		prod = (g * d) >>> 16;
		last_phase_model = phase;
		return prod[OUT_W-1:0];
	endfunction

	// scoreboard and activity counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (freq_expected_q.size() == 0) begin
					$error("freq_out word with nothing expected: got %0d", out_ch.freq_out);
					errors++;
				end else begin
					freq_want = freq_expected_q.pop_front();
					if (out_ch.freq_out !== freq_want) begin
						$error("freq_out mismatch: expected %0d, got %0d",
							freq_want, out_ch.freq_out);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				freq_expected_q.push_back(predict_freq(in_ch.i_sample, in_ch.q_sample));
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// output side: random stalls, plus a long hold when requested
	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_len != 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_GAIN)
			gain_model = data[GAIN_W-1:0];
	endtask

	task automatic check_gain_readback;
		logic [DATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_GAIN;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd[GAIN_W-1:0] !== gain_model) begin
			$error("demod_gain mismatch: expected %0d, got %0d", gain_model, rd[GAIN_W-1:0]);
			errors++;
		end
	endtask

	task automatic send_pair(input logic signed [IN_W-1:0] i_s, input logic signed [IN_W-1:0] q_s);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.i_sample <= i_s;
		in_ch.q_sample <= q_s;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// drop valid, wait for every expected word, then let the pipe settle
	task automatic wait_drained;
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (freq_expected_q.size() != 0);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	// rotating phasor: a well-formed FM-like run with random amplitude and step
	task automatic send_tone(input int len);
		real amp, theta, dtheta;
		int iv, qv;
		amp = ($urandom_range(0, 3) == 0) ? real'($urandom_range(1, 64))
			: real'($urandom_range(1, 32767));
		theta = real'($urandom_range(0, 65535)) * TWO_PI / 65536.0;
		dtheta = (real'($urandom_range(0, 65535)) - 32768.0) * TWO_PI / 65536.0;
		if ($urandom_range(0, 1) == 0)
			dtheta = dtheta / 64.0;
		repeat (len) begin
			iv = $rtoi(amp * $cos(theta));
			qv = $rtoi(amp * $sin(theta));
			send_pair(IN_W'(iv), IN_W'(qv));
			theta = theta + dtheta;
		end
	endtask

	task automatic send_mix(input int n);
		int sent, pick, len;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				len = $urandom_range(5, 40);
				if (len > n - sent)
					len = n - sent;
				send_tone(len);
				sent += len;
			end else if (pick < 9) begin
				send_pair(IN_W'($urandom), IN_W'($urandom));
				sent++;
			end else begin
				// on an axis: Q exactly zero or I exactly zero
				if ($urandom_range(0, 1) == 0)
					send_pair(IN_W'($urandom), '0);
				else
					send_pair('0, IN_W'($urandom));
				sent++;
			end
		end
	endtask

	task automatic test_reset_state;
		check_gain_readback();
	endtask

	task automatic test_directed;
		send_pair(16'sd0, 16'sd0);
		send_pair(16'sd100, 16'sd0);
		send_pair(-16'sd100, 16'sd0);
		send_pair(16'sd100, 16'sd0);
		send_pair(16'sd32767, 16'sd0);
		send_pair(-16'sd32768, 16'sd0);
		send_pair(16'sd0, 16'sd32767);
		send_pair(16'sd0, -16'sd32768);
		send_pair(16'sd32767, 16'sd32767);
		send_pair(-16'sd32768, -16'sd32768);
		send_pair(-16'sd32768, 16'sd32767);
		send_pair(16'sd32767, -16'sd32768);
		send_pair(-16'sd1, 16'sd1);
		send_pair(-16'sd1, -16'sd1);
		send_pair(16'sd1, -16'sd1);
		send_pair(16'sd1, 16'sd1);
		send_pair(-16'sd20000, 16'sd3);
		send_pair(-16'sd20000, -16'sd3);
		send_pair(-16'sd5, 16'sd30000);
		send_pair(-16'sd5, -16'sd30000);
		wait_drained();
	endtask

	task automatic test_gain_extremes;
		reg_write(ADDR_GAIN, '0);
		check_gain_readback();
		send_pair(16'sd100, 16'sd0);
		send_pair(-16'sd100, 16'sd0);
		send_pair(16'sd0, 16'sd77);
		wait_drained();
		reg_write(ADDR_GAIN, DATA_W'(GAIN_MAX));
		check_gain_readback();
		send_pair(16'sd100, 16'sd0);
		send_pair(-16'sd100, 16'sd0);
		send_pair(16'sd100, 16'sd0);
		send_pair(16'sd0, -16'sd9);
		send_pair(16'sd0, 16'sd9);
		wait_drained();
		// an unmapped address leaves the gain alone
		reg_write(ADDR_SPARE, 32'h0000_1234);
		check_gain_readback();
		send_pair(16'sd5000, -16'sd5000);
		send_pair(-16'sd5000, 16'sd5000);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int n, input logic [GAIN_W-1:0] gain);
		reg_write(ADDR_GAIN, DATA_W'(gain));
		send_mix(n);
		wait_drained();
	endtask

	task automatic test_backpressure;
		idle_on = 1'b0;
		hold_len = HOLD_CYCLES;
		send_mix(60);
		wait_drained();
		idle_on = 1'b1;
	endtask

	task automatic test_full_rate;
		idle_on = 1'b0;
		stall_on = 1'b0;
		reg_write(ADDR_GAIN, DATA_W'(GAIN_RESET));
		send_mix(100);
		wait_drained();
	endtask

	initial begin
		errors = 0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		hold_len = 0;
		gain_model = GAIN_RESET;
		last_phase_model = '0;
		arst_n         <= 1'b0;
		in_ch.valid    <= 1'b0;
		in_ch.i_sample <= '0;
		in_ch.q_sample <= '0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed();
		test_gain_extremes();
		test_random_traffic(150, GAIN_W'($urandom));
		test_random_traffic(150, '0);
		test_random_traffic(150, GAIN_MAX);
		test_random_traffic(150, GAIN_W'($urandom_range(1, 1000)));
		test_backpressure();
		test_random_traffic(150, GAIN_W'($urandom));
		test_full_rate();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
